@@ src/hcbc_pkg.sv @@
// Package for the HSV colour blob counter.
// Holds the controller states, the command and status structs and fixed thresholds.
// No dependencies.
`default_nettype none
package hcbc_pkg;

    localparam int CNT_W = 20;
    localparam int ANG_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W = 17;
    localparam int DEN_W = 9;
    localparam int QUO_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RED_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YEL_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLU_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YEL_ANGLE = 3'd4;

    localparam logic [CNT_W-1:0] RST_RED_LIMIT = 20'd20000;
    localparam logic [CNT_W-1:0] RST_YEL_LIMIT = 20'd30000;
    localparam logic [CNT_W-1:0] RST_BLU_LIMIT = 20'd30000;
    localparam logic [ANG_W-1:0] RST_RED_ANGLE = 8'd170;
    localparam logic [ANG_W-1:0] RST_YEL_ANGLE = 8'd10;
    localparam logic [ANG_W-1:0] ANGLE_MAX = 8'd180;

    localparam logic [7:0] HUE_RED_LO = 8'd8;
    localparam logic [7:0] HUE_RED_HI = 8'd168;
    localparam logic [7:0] SAT_HIGH = 8'd100;
    localparam logic [7:0] HUE_YEL_LO = 8'd20;
    localparam logic [7:0] HUE_YEL_HI = 8'd40;
    localparam logic [7:0] SAT_YEL_LO = 8'd20;
    localparam logic [7:0] VAL_YEL_LO = 8'd50;
    localparam logic [7:0] HUE_BLU_LO = 8'd97;
    localparam logic [7:0] HUE_BLU_HI = 8'd117;
    localparam logic [7:0] VAL_BLU_LO = 8'd100;
    localparam logic [7:0] HUE_OFFSET = 8'd30;
    localparam logic [7:0] HUE_WRAP = 8'd150;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S_START,
        ST_S_WAIT,
        ST_H_START,
        ST_H_WAIT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel_h;
        logic save_s;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last;
        logic out_blocked;
    } t_sts;

endpackage
`default_nettype wire

@@ src/hcbc_div.sv @@
// Restoring divider producing an 8-bit quotient, one bit per cycle.
// Uses hcbc_pkg for widths. Quotient is valid for numerator < 256 * divisor.
`default_nettype none
module hcbc_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [hcbc_pkg::NUM_W-1:0]   i_num,
    input  wire logic [hcbc_pkg::DEN_W-1:0]   i_den,
    output logic                              o_done,
    output logic [hcbc_pkg::QUO_W-1:0]        o_quo
);
    localparam int DSH_W = hcbc_pkg::DEN_W + hcbc_pkg::QUO_W - 1;

    logic [hcbc_pkg::NUM_W-1:0] r_rem, n_rem;
    logic [DSH_W-1:0]           r_dsh;
    logic [hcbc_pkg::QUO_W-1:0] r_quo;
    logic [2:0]                 r_cnt;
    logic                       r_busy, r_done;
    logic                       fits;

    always_comb begin
        fits  = r_rem >= {{(hcbc_pkg::NUM_W-DSH_W){1'b0}}, r_dsh};
        n_rem = fits ? r_rem - {{(hcbc_pkg::NUM_W-DSH_W){1'b0}}, r_dsh} : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {i_den, {(hcbc_pkg::QUO_W-1){1'b0}}};
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[hcbc_pkg::QUO_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

@@ src/hcbc_ctrl.sv @@
// Controller state machine: sequences the saturation and hue divisions per pixel.
// Uses hcbc_pkg for the state type and the command and status structs.
`default_nettype none
module hcbc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pix_valid,
    output logic               o_pix_stall,
    input  wire hcbc_pkg::t_sts i_sts,
    output hcbc_pkg::t_cmd     o_cmd
);
    hcbc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_pix_stall = 1'b1;
        unique case (r_state)
            hcbc_pkg::ST_IDLE: begin
                o_pix_stall = 1'b0;
                if (i_pix_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = hcbc_pkg::ST_S_START;
                end
            end
            hcbc_pkg::ST_S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = hcbc_pkg::ST_S_WAIT;
            end
            hcbc_pkg::ST_S_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.save_s = 1'b1;
                    n_state      = hcbc_pkg::ST_H_START;
                end
            end
            hcbc_pkg::ST_H_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_h = 1'b1;
                n_state         = hcbc_pkg::ST_H_WAIT;
            end
            hcbc_pkg::ST_H_WAIT: begin
                o_cmd.div_sel_h = 1'b1;
                if (i_sts.div_done) begin
                    n_state = hcbc_pkg::ST_FIN;
                end
            end
            hcbc_pkg::ST_FIN: begin
                o_cmd.div_sel_h = 1'b1;
                if (!(i_sts.last && i_sts.out_blocked)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = hcbc_pkg::ST_IDLE;
                end
            end
            default: n_state = hcbc_pkg::ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && !o_pix_stall) |=> (r_state == hcbc_pkg::ST_S_START))
        else $error("accepted pixel did not start the saturation division");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == hcbc_pkg::ST_S_WAIT || r_state == hcbc_pkg::ST_H_WAIT))
        else $error("divider finished outside a wait state");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish && i_sts.last) |-> !i_sts.out_blocked)
        else $error("result would overwrite a pending result");
`endif
endmodule
`default_nettype wire

@@ src/hcbc_dp.sv @@
// Datapath: HSV conversion, classification, saturating counters, config and result register.
// Uses hcbc_pkg and instantiates hcbc_div.
`default_nettype none
module hcbc_dp #(
    parameter int MAX_FRAME_PIXELS = 524288
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire hcbc_pkg::t_cmd                  i_cmd,
    output hcbc_pkg::t_sts                       o_sts,
    input  wire logic [7:0]                      i_pixel_blue,
    input  wire logic [7:0]                      i_pixel_green,
    input  wire logic [7:0]                      i_pixel_red,
    input  wire logic                            i_last_pixel,
    input  wire logic                            i_cfg_we,
    input  wire logic [hcbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hcbc_pkg::CNT_W-1:0]      i_cfg_data,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_stall,
    output logic [hcbc_pkg::CNT_W-1:0]           o_red_total,
    output logic [hcbc_pkg::CNT_W-1:0]           o_yellow_total,
    output logic [hcbc_pkg::CNT_W-1:0]           o_blue_total,
    output logic                                 o_red_found,
    output logic                                 o_yellow_found,
    output logic                                 o_blue_found,
    output logic                                 o_servo_valid,
    output logic [hcbc_pkg::ANG_W-1:0]           o_servo_angle
);
    localparam int CW = hcbc_pkg::CNT_W;
    localparam int CAP_INT = (MAX_FRAME_PIXELS > (2**CW - 1)) ? (2**CW - 1) : MAX_FRAME_PIXELS;
    localparam logic [CW-1:0] CNT_CAP = CW'(CAP_INT);

    logic [CW-1:0] r_red_lim, r_yel_lim, r_blu_lim;
    logic [7:0]    r_red_ang, r_yel_ang;
    logic [CW-1:0] r_red_cnt, r_yel_cnt, r_blu_cnt;
    logic [7:0]    r_v, r_diff, r_s;
    logic [10:0]   r_off;
    logic          r_last;
    logic [7:0]    mx, mn, dv;
    logic [10:0]   off;
    logic [hcbc_pkg::NUM_W-1:0] div_num;
    logic [hcbc_pkg::DEN_W-1:0] div_den;
    logic [7:0]    quo, h;
    logic          div_done;
    logic          is_red, is_yel, is_blu;
    logic [CW-1:0] n_red_cnt, n_yel_cnt, n_blu_cnt;
    logic          rf, yf, bf;
    logic [7:0]    ang;
    logic          r_out_valid;

    always_comb begin
        mx = i_pixel_red;
        mn = i_pixel_red;
        if (i_pixel_green > mx) mx = i_pixel_green;
        if (i_pixel_blue > mx)  mx = i_pixel_blue;
        if (i_pixel_green < mn) mn = i_pixel_green;
        if (i_pixel_blue < mn)  mn = i_pixel_blue;
        dv = mx - mn;
        // Sector numerator offset by one diff so it never goes negative.
        priority if (mx == i_pixel_red) begin
            off = 11'(i_pixel_green) + 11'(dv) - 11'(i_pixel_blue);
        end else if (mx == i_pixel_green) begin
            off = 11'(i_pixel_blue) + 11'(3 * 11'(dv)) - 11'(i_pixel_red);
        end else begin
            off = 11'(i_pixel_red) + 11'(5 * 11'(dv)) - 11'(i_pixel_green);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= mx;
            r_diff <= dv;
            r_off  <= off;
            r_last <= i_last_pixel;
        end
        if (i_cmd.save_s) begin
            r_s <= (r_v == 8'd0) ? 8'd0 : quo;
        end
    end

    always_comb begin
        if (i_cmd.div_sel_h) begin
            div_num = 17'(17'd60 * 17'(r_off)) + 17'(r_diff);
            div_den = {r_diff, 1'b0};
        end else begin
            div_num = 17'(17'd510 * 17'(r_diff)) + 17'(r_v);
            div_den = {r_v, 1'b0};
        end
    end

    hcbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_comb begin
        if (r_diff == 8'd0) begin
            h = 8'd0;
        end else if (quo < hcbc_pkg::HUE_OFFSET) begin
            h = quo + hcbc_pkg::HUE_WRAP;
        end else begin
            h = quo - hcbc_pkg::HUE_OFFSET;
        end
        is_red = (h < hcbc_pkg::HUE_RED_LO || h > hcbc_pkg::HUE_RED_HI)
                 && r_s > hcbc_pkg::SAT_HIGH;
        is_yel = h > hcbc_pkg::HUE_YEL_LO && h < hcbc_pkg::HUE_YEL_HI
                 && r_s > hcbc_pkg::SAT_YEL_LO && r_s < hcbc_pkg::SAT_HIGH
                 && r_v > hcbc_pkg::VAL_YEL_LO;
        is_blu = h > hcbc_pkg::HUE_BLU_LO && h < hcbc_pkg::HUE_BLU_HI
                 && r_s > hcbc_pkg::SAT_HIGH && r_v > hcbc_pkg::VAL_BLU_LO;
        n_red_cnt = (is_red && r_red_cnt < CNT_CAP) ? r_red_cnt + CW'(1) : r_red_cnt;
        n_yel_cnt = (is_yel && r_yel_cnt < CNT_CAP) ? r_yel_cnt + CW'(1) : r_yel_cnt;
        n_blu_cnt = (is_blu && r_blu_cnt < CNT_CAP) ? r_blu_cnt + CW'(1) : r_blu_cnt;
        rf = n_red_cnt > r_red_lim;
        yf = n_yel_cnt > r_yel_lim;
        bf = n_blu_cnt > r_blu_lim;
        if (yf)      ang = r_yel_ang;
        else if (rf) ang = r_red_ang;
        else         ang = 8'd0;
        if (ang > hcbc_pkg::ANGLE_MAX) ang = hcbc_pkg::ANGLE_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_lim   <= hcbc_pkg::RST_RED_LIMIT;
            r_yel_lim   <= hcbc_pkg::RST_YEL_LIMIT;
            r_blu_lim   <= hcbc_pkg::RST_BLU_LIMIT;
            r_red_ang   <= hcbc_pkg::RST_RED_ANGLE;
            r_yel_ang   <= hcbc_pkg::RST_YEL_ANGLE;
            r_red_cnt   <= '0;
            r_yel_cnt   <= '0;
            r_blu_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hcbc_pkg::CFG_RED_LIMIT: r_red_lim <= i_cfg_data;
                    hcbc_pkg::CFG_YEL_LIMIT: r_yel_lim <= i_cfg_data;
                    hcbc_pkg::CFG_BLU_LIMIT: r_blu_lim <= i_cfg_data;
                    hcbc_pkg::CFG_RED_ANGLE: r_red_ang <= i_cfg_data[7:0];
                    hcbc_pkg::CFG_YEL_ANGLE: r_yel_ang <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // A new result may be loaded at the same edge as the old one transfers.
            if (i_cmd.finish && r_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_res_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_red_cnt   <= '0;
                    r_yel_cnt   <= '0;
                    r_blu_cnt   <= '0;
                end else begin
                    r_red_cnt <= n_red_cnt;
                    r_yel_cnt <= n_yel_cnt;
                    r_blu_cnt <= n_blu_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_last) begin
            o_red_total    <= n_red_cnt;
            o_yellow_total <= n_yel_cnt;
            o_blue_total   <= n_blu_cnt;
            o_red_found    <= rf;
            o_yellow_found <= yf;
            o_blue_found   <= bf;
            o_servo_valid  <= rf | yf;
            o_servo_angle  <= ang;
        end
    end

    assign o_res_valid = r_out_valid;

    always_comb begin
        o_sts.div_done    = div_done;
        o_sts.last        = r_last;
        o_sts.out_blocked = r_out_valid & i_res_stall;
    end
endmodule
`default_nettype wire

@@ src/hsv_color_blob_counter.sv @@
// HSV colour blob counter: per-frame red, yellow and blue pixel counts with servo command.
// Top level; instantiates hcbc_ctrl and hcbc_dp, uses hcbc_pkg.
//
// Usage:
//  - Pixel channel (i_pix_valid / o_pix_stall) takes one BGR pixel per transfer, with
//    i_last_pixel marking the end of a frame.
//  - Each pixel occupies the block until it is finished: one state takes it in, two divisions
//    (saturation, then hue) run on a single shared bit-serial divider (a start state, a
//    wait while it iterates bit by bit, and pickup of the quotient), and a finishing
//    state follows. The divider sets the rate; no new pixel is taken meanwhile.
//  - On the last pixel of a frame one result transfer appears on the result channel
//    (o_res_valid / i_res_stall) once the finishing state has registered the result;
//    the counters then restart at zero.
//  - The result register holds its value while the receiver stalls; further pixels
//    are taken meanwhile, and only the next last pixel waits until it is free.
//  - Configuration writes (i_cfg_valid / o_cfg_ready) are always ready and should be
//    made while no pixel is in progress.
//  - Synchronous reset clears the counters, loads the register defaults and drops
//    any pending result.
`default_nettype none
module hsv_color_blob_counter #(
    parameter int MAX_FRAME_PIXELS = 524288
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_pix_valid,
    output logic                                 o_pix_stall,
    input  wire logic [7:0]                      i_pixel_blue,
    input  wire logic [7:0]                      i_pixel_green,
    input  wire logic [7:0]                      i_pixel_red,
    input  wire logic                            i_last_pixel,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [hcbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hcbc_pkg::CNT_W-1:0]      i_cfg_data,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_stall,
    output logic [hcbc_pkg::CNT_W-1:0]           o_red_total,
    output logic [hcbc_pkg::CNT_W-1:0]           o_yellow_total,
    output logic [hcbc_pkg::CNT_W-1:0]           o_blue_total,
    output logic                                 o_red_found,
    output logic                                 o_yellow_found,
    output logic                                 o_blue_found,
    output logic                                 o_servo_valid,
    output logic [hcbc_pkg::ANG_W-1:0]           o_servo_angle
);
    hcbc_pkg::t_cmd cmd;
    hcbc_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    hcbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_stall (o_pix_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hcbc_dp #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_pixel_blue   (i_pixel_blue),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_red    (i_pixel_red),
        .i_last_pixel   (i_last_pixel),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_red_total    (o_red_total),
        .o_yellow_total (o_yellow_total),
        .o_blue_total   (o_blue_total),
        .o_red_found    (o_red_found),
        .o_yellow_found (o_yellow_found),
        .o_blue_found   (o_blue_found),
        .o_servo_valid  (o_servo_valid),
        .o_servo_angle  (o_servo_angle)
    );
endmodule
`default_nettype wire
